FILE: rtl/bss_pkg.sv
package bss_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int WEIGHT_W       = 31;
  localparam int HOMOG_W        = 47;
  localparam int ALPHA_W        = 17;
  localparam int DEG_W          = 2;
  localparam int MAX_DEGREE_DEF = 3;
  localparam int DIV_W          = 33;
  localparam int QUO_W          = 32;
  localparam int STEP_W         = 6;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_U   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_V   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIONAL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_U_BEG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_U_END = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_V_BEG = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_V_END = 3'd6;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_SPLIT = 1'b1;

  localparam logic [WEIGHT_W-1:0] ONE_Q16   = 31'd65536;
  localparam logic [ALPHA_W-1:0]  ALPHA_ONE = 17'd65536;
  localparam logic [STEP_W-1:0]   ALPHA_STEPS = 6'd17;
  localparam logic [STEP_W-1:0]   COORD_STEPS = 6'd32;

  typedef logic signed [HOMOG_W-1:0] homog_t;
  typedef homog_t [3:0] hpoint_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  rem0;
    logic [QUO_W-1:0]  low;
    logic [DIV_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

FILE: rtl/bss_in_if.sv
interface bss_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   kind;
  logic [bss_pkg::DEG_W-1:0]              grid_row;
  logic [bss_pkg::DEG_W-1:0]              grid_col;
  logic signed [bss_pkg::COORD_WIDTH-1:0] coord_x;
  logic signed [bss_pkg::COORD_WIDTH-1:0] coord_y;
  logic signed [bss_pkg::COORD_WIDTH-1:0] coord_z;
  logic [bss_pkg::WEIGHT_W-1:0]           point_weight;
  logic signed [bss_pkg::COORD_WIDTH-1:0] split_at;
  logic                                   split_dir;

  modport source(output valid, kind, grid_row, grid_col, coord_x, coord_y, coord_z,
                 point_weight, split_at, split_dir, input ready);
  modport sink(input valid, kind, grid_row, grid_col, coord_x, coord_y, coord_z,
               point_weight, split_at, split_dir, output ready);
endinterface

FILE: rtl/bss_out_if.sv
interface bss_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   side;
  logic [bss_pkg::DEG_W-1:0]              out_row;
  logic [bss_pkg::DEG_W-1:0]              out_col;
  logic signed [bss_pkg::COORD_WIDTH-1:0] out_x;
  logic signed [bss_pkg::COORD_WIDTH-1:0] out_y;
  logic signed [bss_pkg::COORD_WIDTH-1:0] out_z;
  logic [bss_pkg::WEIGHT_W-1:0]           out_weight;
  logic                                   last;

  modport source(output valid, side, out_row, out_col, out_x, out_y, out_z, out_weight,
                 last, input ready);
  modport sink(input valid, side, out_row, out_col, out_x, out_y, out_z, out_weight,
               last, output ready);
endinterface

FILE: rtl/bezier_surface_split_top.sv
// Loads give no output beat and leave the block ready for the next item.
// A split computes alpha, runs the homogeneous pass over every grid point, blends
// each line by de Casteljau, then emits the beats, using the divider for up to
// three divisions for each interior rational point.
// One item is worked at a time; the blend unit and the shared divider set the pace.
// Synchronous active-low reset clears control and sets configuration to defaults; the grid is undefined.
module bezier_surface_split_top #(
  parameter int MAX_DEGREE = bss_pkg::MAX_DEGREE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  bss_in_if.sink                           in_bus,
  bss_out_if.source                        out_bus,
  input  logic                             cfg_we,
  input  logic [bss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bss_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW    = bss_pkg::COORD_WIDTH;
  localparam int WW    = bss_pkg::WEIGHT_W;
  localparam int HW    = bss_pkg::HOMOG_W;
  localparam int DGW   = bss_pkg::DEG_W;
  localparam int GS    = MAX_DEGREE + 1;
  localparam int GS2   = GS * GS;
  localparam int SA    = $clog2(GS2);
  localparam int WA    = SA + 1;
  localparam int ST_W  = 3 * CW + WW;
  localparam int WK_W  = 4 * HW;
  localparam int WK_D  = 2 * (2 ** SA);

  localparam logic [SA-1:0]  GS_A   = SA'(GS);
  localparam logic [SA-1:0]  N_LAST = SA'(GS2 - 1);
  localparam logic [DGW-1:0] MAX_D  = DGW'(MAX_DEGREE);
  localparam logic [CW-1:0]  C_MAX  = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0]  C_MIN  = {1'b1, {(CW-1){1'b0}}};

  // sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ALPHA = 5'd1;
  localparam logic [4:0] S_AWAIT = 5'd2;
  localparam logic [4:0] S_HRD   = 5'd3;
  localparam logic [4:0] S_HLAT  = 5'd4;
  localparam logic [4:0] S_HMUL  = 5'd5;
  localparam logic [4:0] S_HWR   = 5'd6;
  localparam logic [4:0] S_BRD   = 5'd7;
  localparam logic [4:0] S_BLAT  = 5'd8;
  localparam logic [4:0] S_BWAIT = 5'd9;
  localparam logic [4:0] S_BWR   = 5'd10;
  localparam logic [4:0] S_BWR2  = 5'd11;
  localparam logic [4:0] S_ERD   = 5'd12;
  localparam logic [4:0] S_ELAT  = 5'd13;
  localparam logic [4:0] S_EDST  = 5'd14;
  localparam logic [4:0] S_EDWT  = 5'd15;
  localparam logic [4:0] S_EOUT  = 5'd16;

  // row-major grid address
  function automatic logic [SA-1:0] grid_idx(input logic [DGW-1:0] r,
                                             input logic [DGW-1:0] c);
    grid_idx = SA'(r) * GS_A + SA'(c);
  endfunction

  // configuration
  logic [DGW-1:0]       degree_u_r, degree_v_r;
  logic                 rational_r;
  logic signed [CW-1:0] su_beg_r, su_end_r, sv_beg_r, sv_end_r;

  // sequencer
  logic [4:0]           state_r;
  logic                 dir_r;
  logic signed [CW-1:0] t_r;
  logic [bss_pkg::ALPHA_W-1:0] alpha_r;
  logic [SA-1:0]        n_r;
  logic [1:0]           hc_r;
  logic [ST_W-1:0]      sd_r;
  logic signed [CW+WW:0] prod_r;
  bss_pkg::homog_t      hv_r [3];
  logic [DGW-1:0]       ln_r, k_r, p_r;
  logic                 s_r;
  logic [DGW-1:0]       i_r, j_r;
  bss_pkg::hpoint_t     wd_r;
  logic [1:0]           dq_r;
  logic [CW-1:0]        ov_r [3];

  // output register
  logic                 out_valid_r;
  logic                 side_r, last_r;
  logic [DGW-1:0]       row_r, col_r;
  logic [CW-1:0]        ox_r, oy_r, oz_r;
  logic [WW-1:0]        ow_r;

  logic [DGW-1:0]       du, dv, lines_c, deg_c, pos_c;
  logic                 in_acc, is_end, out_free;

  // memories
  logic                 st_we;
  logic [SA-1:0]        st_waddr, st_raddr;
  logic [ST_W-1:0]      st_wdata, st_rdata, st_rdata_b;
  logic                 wk_we;
  logic [WA-1:0]        wk_waddr, wk_raddr_a, wk_raddr_b;
  logic [WK_W-1:0]      wk_wdata, wk_rdata_a, wk_rdata_b;
  bss_pkg::hpoint_t     hom_wr;

  // units
  bss_pkg::div_req_t    div_req;
  logic                 div_busy, div_done;
  logic [bss_pkg::QUO_W-1:0] div_quot;
  logic                 lerp_start, lerp_busy, lerp_done;
  bss_pkg::hpoint_t     lerp_res;

  // alpha setup
  logic signed [CW-1:0] st_c, en_c, tc_c;
  logic [CW:0]          m_c, d_c;
  logic                 span_ok;

  // emission division setup
  bss_pkg::homog_t      h_c;
  logic [HW-1:0]        hx_c, hws_c;
  logic [WW-1:0]        hw_c;
  logic                 big_c, hw_zero;
  logic [CW-1:0]        sat_c, qres_c;

  logic signed [CW-1:0] mc_c;

  assign in_acc   = in_bus.valid && in_bus.ready;
  assign in_bus.ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_bus.ready;

  assign du      = (degree_u_r > MAX_D) ? MAX_D : degree_u_r;
  assign dv      = (degree_v_r > MAX_D) ? MAX_D : degree_v_r;
  assign lines_c = dir_r ? du : dv;
  assign deg_c   = dir_r ? dv : du;
  assign pos_c   = dir_r ? j_r : i_r;
  assign is_end  = (!s_r && pos_c == '0) || (s_r && pos_c == deg_c);

  // clamp the split value into the span and form the divider operands
  always_comb begin
    st_c    = dir_r ? sv_beg_r : su_beg_r;
    en_c    = dir_r ? sv_end_r : su_end_r;
    span_ok = en_c > st_c;
    if (t_r < st_c) begin
      tc_c = st_c;
    end else if (t_r > en_c) begin
      tc_c = en_c;
    end else begin
      tc_c = t_r;
    end
    m_c = {tc_c[CW-1], tc_c} - {st_c[CW-1], st_c};
    d_c = {en_c[CW-1], en_c} - {st_c[CW-1], st_c};
  end

  // rational output: |h| * 1.0 / hw, saturated to the coordinate range
  always_comb begin
    h_c     = wd_r[dq_r];
    hw_c    = wd_r[3][WW-1:0];
    hx_c    = h_c[HW-1] ? HW'(-h_c) : HW'(h_c);
    hws_c   = {hw_c, 16'b0};
    big_c   = hx_c >= hws_c;
    hw_zero = (hw_c == '0);
    sat_c   = h_c[HW-1] ? C_MIN : C_MAX;
    if (!h_c[HW-1]) begin
      qres_c = div_quot[CW-1] ? C_MAX : div_quot;
    end else begin
      qres_c = (div_quot > C_MIN) ? C_MIN : (~div_quot + 1'b1);
    end
  end

  always_comb begin
    div_req = '0;
    if (state_r == S_ALPHA) begin
      div_req.start   = span_ok;
      div_req.rem0    = {1'b0, m_c[CW:1]};
      div_req.low     = {m_c[0], {(bss_pkg::QUO_W-1){1'b0}}};
      div_req.divisor = d_c;
      div_req.steps   = bss_pkg::ALPHA_STEPS;
    end else begin
      div_req.start   = (state_r == S_EDST) && !hw_zero && !big_c;
      div_req.rem0    = bss_pkg::DIV_W'(hx_c[HW-1:16]);
      div_req.low     = {hx_c[15:0], 16'b0};
      div_req.divisor = bss_pkg::DIV_W'(hw_c);
      div_req.steps   = bss_pkg::COORD_STEPS;
    end
  end

  // homogeneous multiply operand
  always_comb begin
    unique case (hc_r)
      2'd0:    mc_c = sd_r[CW-1:0];
      2'd1:    mc_c = sd_r[2*CW-1:CW];
      default: mc_c = sd_r[3*CW-1:2*CW];
    endcase
  end

  always_comb begin
    if (rational_r) begin
      hom_wr = {HW'(sd_r[ST_W-1:3*CW]), hv_r[2], hv_r[1], hv_r[0]};
    end else begin
      hom_wr = {HW'(bss_pkg::ONE_Q16),
                HW'($signed(sd_r[3*CW-1:2*CW])),
                HW'($signed(sd_r[2*CW-1:CW])),
                HW'($signed(sd_r[CW-1:0]))};
    end
  end

  // memory ports
  assign st_we    = in_acc && (in_bus.kind == bss_pkg::KIND_LOAD) &&
                    (in_bus.grid_row <= MAX_D) && (in_bus.grid_col <= MAX_D);
  assign st_waddr = grid_idx(in_bus.grid_row, in_bus.grid_col);
  assign st_wdata = {in_bus.point_weight, in_bus.coord_z, in_bus.coord_y, in_bus.coord_x};
  assign st_raddr = (state_r == S_ERD) ? grid_idx(i_r, j_r) : n_r;

  always_comb begin
    wk_we    = 1'b0;
    wk_waddr = {1'b0, n_r};
    wk_wdata = lerp_res;
    unique case (state_r)
      S_HWR: begin
        wk_we    = 1'b1;
        wk_wdata = hom_wr;
      end
      S_BWR: begin
        wk_we    = 1'b1;
        wk_waddr = {1'b0, dir_r ? grid_idx(ln_r, p_r) : grid_idx(p_r, ln_r)};
      end
      S_BWR2: begin
        wk_we    = 1'b1;
        wk_waddr = {1'b1, dir_r ? grid_idx(ln_r, deg_c - k_r)
                                : grid_idx(deg_c - k_r, ln_r)};
      end
      default: begin
        wk_we = 1'b0;
      end
    endcase
  end

  assign wk_raddr_a = (state_r == S_ERD) ? {s_r, grid_idx(i_r, j_r)}
                    : {1'b0, dir_r ? grid_idx(ln_r, p_r) : grid_idx(p_r, ln_r)};
  assign wk_raddr_b = {1'b0, dir_r ? grid_idx(ln_r, p_r - 1'b1)
                                   : grid_idx(p_r - 1'b1, ln_r)};
  assign lerp_start = (state_r == S_BLAT);

  bss_ram #(.WIDTH(ST_W), .DEPTH(GS2)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr_a(st_raddr), .rdata_a(st_rdata), .raddr_b(st_raddr), .rdata_b(st_rdata_b)
  );

  bss_ram #(.WIDTH(WK_W), .DEPTH(WK_D)) u_work (
    .clk(clk), .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata),
    .raddr_a(wk_raddr_a), .rdata_a(wk_rdata_a),
    .raddr_b(wk_raddr_b), .rdata_b(wk_rdata_b)
  );

  bss_div u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req),
    .busy(div_busy), .done(div_done), .quot(div_quot)
  );

  bss_lerp u_lerp (
    .clk(clk), .rst_n(rst_n), .start(lerp_start), .alpha(alpha_r),
    .a(wk_rdata_a), .b(wk_rdata_b),
    .busy(lerp_busy), .done(lerp_done), .res(lerp_res)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_u_r <= 2'd3;
      degree_v_r <= 2'd3;
      rational_r <= 1'b0;
      su_beg_r   <= '0;
      su_end_r   <= CW'(65536);
      sv_beg_r   <= '0;
      sv_end_r   <= CW'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bss_pkg::CFG_DEGREE_U:   degree_u_r <= cfg_data[DGW-1:0];
        bss_pkg::CFG_DEGREE_V:   degree_v_r <= cfg_data[DGW-1:0];
        bss_pkg::CFG_RATIONAL:   rational_r <= cfg_data[0];
        bss_pkg::CFG_SPAN_U_BEG: su_beg_r   <= cfg_data;
        bss_pkg::CFG_SPAN_U_END: su_end_r   <= cfg_data;
        bss_pkg::CFG_SPAN_V_BEG: sv_beg_r   <= cfg_data;
        bss_pkg::CFG_SPAN_V_END: sv_end_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // output valid: load a new beat, or drop the held one once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EOUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // sequencer: alpha, homogeneous pass, blends line by line, then emission
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r  <= '0;
      hc_r <= '0;
      ln_r <= '0;
      k_r  <= '0;
      p_r  <= '0;
      s_r  <= 1'b0;
      i_r  <= '0;
      j_r  <= '0;
      dq_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_bus.kind == bss_pkg::KIND_SPLIT) begin
            state_r <= S_ALPHA;
          end
        end
        S_ALPHA: begin
          n_r <= '0;
          state_r <= span_ok ? S_AWAIT : S_HRD;
        end
        S_AWAIT: begin
          if (div_done) begin
            state_r <= S_HRD;
          end
        end
        S_HRD: state_r <= S_HLAT;
        S_HLAT: begin
          hc_r    <= '0;
          state_r <= rational_r ? S_HMUL : S_HWR;
        end
        S_HMUL: begin
          hc_r <= hc_r + 1'b1;
          if (hc_r == 2'd3) begin
            state_r <= S_HWR;
          end
        end
        S_HWR: begin
          if (n_r == N_LAST) begin
            ln_r <= '0;
            k_r  <= DGW'(1);
            p_r  <= deg_c;
            s_r  <= 1'b0;
            i_r  <= '0;
            j_r  <= '0;
            state_r <= (deg_c == '0) ? S_ERD : S_BRD;
          end else begin
            n_r     <= n_r + 1'b1;
            state_r <= S_HRD;
          end
        end
        S_BRD:  state_r <= S_BLAT;
        S_BLAT: state_r <= S_BWAIT;
        S_BWAIT: begin
          if (lerp_done) begin
            state_r <= S_BWR;
          end
        end
        S_BWR, S_BWR2: begin
          if (state_r == S_BWR && p_r == deg_c) begin
            // the top point of this step is also the right half's next point
            state_r <= S_BWR2;
          end else if (p_r > k_r) begin
            p_r     <= p_r - 1'b1;
            state_r <= S_BRD;
          end else if (k_r < deg_c) begin
            k_r     <= k_r + 1'b1;
            p_r     <= deg_c;
            state_r <= S_BRD;
          end else if (ln_r < lines_c) begin
            ln_r    <= ln_r + 1'b1;
            k_r     <= DGW'(1);
            p_r     <= deg_c;
            state_r <= S_BRD;
          end else begin
            state_r <= S_ERD;
          end
        end
        S_ERD: state_r <= S_ELAT;
        S_ELAT: begin
          dq_r    <= '0;
          state_r <= (is_end || !rational_r) ? S_EOUT : S_EDST;
        end
        S_EDST: begin
          if (hw_zero || big_c) begin
            dq_r <= dq_r + 1'b1;
            if (dq_r == 2'd2) begin
              state_r <= S_EOUT;
            end
          end else begin
            state_r <= S_EDWT;
          end
        end
        S_EDWT: begin
          if (div_done) begin
            dq_r    <= dq_r + 1'b1;
            state_r <= (dq_r == 2'd2) ? S_EOUT : S_EDST;
          end
        end
        S_EOUT: begin
          if (out_free) begin
            if (j_r < dv) begin
              j_r     <= j_r + 1'b1;
              state_r <= S_ERD;
            end else if (i_r < du) begin
              i_r     <= i_r + 1'b1;
              j_r     <= '0;
              state_r <= S_ERD;
            end else if (!s_r) begin
              s_r     <= 1'b1;
              i_r     <= '0;
              j_r     <= '0;
              state_r <= S_ERD;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dir_r <= in_bus.split_dir;
      t_r   <= in_bus.split_at;
    end
    if (state_r == S_ALPHA && !span_ok) begin
      alpha_r <= '0;
    end
    if (state_r == S_AWAIT && div_done) begin
      alpha_r <= div_quot[bss_pkg::ALPHA_W-1:0];
    end
    if (state_r == S_HLAT || state_r == S_ELAT) begin
      sd_r <= st_rdata;
    end
    if (state_r == S_ELAT) begin
      wd_r <= wk_rdata_a;
    end
    if (state_r == S_HMUL) begin
      if (hc_r != 2'd3) begin
        prod_r <= mc_c * $signed({1'b0, sd_r[ST_W-1:3*CW]});
      end
      if (hc_r != 2'd0) begin
        hv_r[hc_r - 1'b1] <= HW'(prod_r >>> 16);
      end
    end
    if (state_r == S_EDST && (hw_zero || big_c)) begin
      ov_r[dq_r] <= hw_zero ? '0 : sat_c;
    end
    if (state_r == S_EDWT && div_done) begin
      ov_r[dq_r] <= qres_c;
    end
    if (state_r == S_EOUT && out_free) begin
      side_r <= s_r;
      row_r  <= i_r;
      col_r  <= j_r;
      last_r <= s_r && (i_r == du) && (j_r == dv);
      if (is_end) begin
        ox_r <= sd_r[CW-1:0];
        oy_r <= sd_r[2*CW-1:CW];
        oz_r <= sd_r[3*CW-1:2*CW];
        ow_r <= rational_r ? sd_r[ST_W-1:3*CW] : bss_pkg::ONE_Q16;
      end else if (!rational_r) begin
        ox_r <= wd_r[0][CW-1:0];
        oy_r <= wd_r[1][CW-1:0];
        oz_r <= wd_r[2][CW-1:0];
        ow_r <= bss_pkg::ONE_Q16;
      end else begin
        ox_r <= ov_r[0];
        oy_r <= ov_r[1];
        oz_r <= ov_r[2];
        ow_r <= wd_r[3][WW-1:0];
      end
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.side       = side_r;
  assign out_bus.out_row    = row_r;
  assign out_bus.out_col    = col_r;
  assign out_bus.out_x      = ox_r;
  assign out_bus.out_y      = oy_r;
  assign out_bus.out_z      = oz_r;
  assign out_bus.out_weight = ow_r;
  assign out_bus.last       = last_r;

  // the shared divider must be idle when a new division is issued
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");

  // the blend unit must be idle when a new blend is issued
  a_lerp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    lerp_start |-> !lerp_busy)
    else $error("blend unit started while busy");

  // alpha stays within 0..1.0 once the homogeneous pass starts
  a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HRD) |-> (alpha_r <= bss_pkg::ALPHA_ONE))
    else $error("alpha out of range");

  // the work memory is only written while a split is in progress
  a_work_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !wk_we)
    else $error("work memory written while idle");

endmodule

FILE: rtl/bss_ram.sv
module bss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: rtl/bss_div.sv
module bss_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bss_pkg::div_req_t            req,
  output logic                         busy,
  output logic                         done,
  output logic [bss_pkg::QUO_W-1:0]    quot
);

  localparam int DW = bss_pkg::DIV_W;
  localparam int QW = bss_pkg::QUO_W;

  logic [DW-1:0]               rem_r, rem_nxt;
  logic [QW-1:0]               low_r;
  logic [DW-1:0]               dvs_r;
  logic [QW-1:0]               quot_r;
  logic [bss_pkg::STEP_W-1:0]  cnt_r;
  logic                        busy_r, done_r;
  logic [DW:0]                 trial, diff;
  logic                        ge;

  // one quotient bit per cycle: shift in the next dividend bit, trial subtract
  always_comb begin
    trial   = {rem_r, low_r[QW-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.rem0;
      low_r  <= req.low;
      dvs_r  <= req.divisor;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      low_r  <= {low_r[QW-2:0], 1'b0};
      quot_r <= {quot_r[QW-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quot_r;

endmodule

FILE: rtl/bss_lerp.sv
module bss_lerp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bss_pkg::ALPHA_W-1:0]   alpha,
  input  bss_pkg::hpoint_t              a,
  input  bss_pkg::hpoint_t              b,
  output logic                          busy,
  output logic                          done,
  output bss_pkg::hpoint_t              res
);

  localparam int HW    = bss_pkg::HOMOG_W;
  localparam int AW    = bss_pkg::ALPHA_W;
  localparam int DL_W  = (HW + 1) / 2;
  localparam int DH_W  = HW + 1 - DL_W;
  localparam int PL_W  = DL_W + AW;
  localparam int PH_W  = DH_W + AW + 1;
  localparam int SUM_W = HW + AW + 2;

  logic signed [HW:0]     d_r [4];
  bss_pkg::homog_t        b_r [4];
  logic [AW-1:0]          alpha_r;
  logic [1:0]             q_r;
  logic [1:0]             ph_r;
  logic [PL_W-1:0]        lo_r;
  logic signed [PH_W-1:0] hi_r;
  bss_pkg::hpoint_t       res_r;
  logic                   busy_r, done_r;

  logic signed [HW:0]     d_sel;
  logic [DL_W-1:0]        d_lo;
  logic signed [DH_W-1:0] d_hi;
  logic [PL_W-1:0]        lo_nxt;
  logic signed [PH_W-1:0] hi_nxt;
  logic signed [SUM_W-1:0] prod, shf, sum_b;
  bss_pkg::homog_t        b_sel;

  // d*alpha split into a low unsigned and a high signed partial product
  always_comb begin
    d_sel  = d_r[q_r];
    b_sel  = b_r[q_r];
    d_lo   = d_sel[DL_W-1:0];
    d_hi   = d_sel[HW:DL_W];
    lo_nxt = {{AW{1'b0}}, d_lo} * {{DL_W{1'b0}}, alpha_r};
    hi_nxt = PH_W'(d_hi) * $signed({{(PH_W-AW){1'b0}}, alpha_r});
    prod   = (SUM_W'(hi_r) <<< DL_W) + $signed({{(SUM_W-PL_W){1'b0}}, lo_r});
    shf    = prod >>> 16;
    sum_b  = SUM_W'(b_sel) + shf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      q_r    <= '0;
      ph_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        q_r    <= '0;
        ph_r   <= '0;
      end else if (busy_r) begin
        if (ph_r == 2'd2) begin
          ph_r <= '0;
          if (q_r == 2'd3) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            q_r <= q_r + 1'b1;
          end
        end else begin
          ph_r <= ph_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      alpha_r <= alpha;
      for (int i = 0; i < 4; i++) begin
        d_r[i] <= $signed({a[i][HW-1], a[i]}) - $signed({b[i][HW-1], b[i]});
        b_r[i] <= b[i];
      end
    end else if (busy_r) begin
      unique case (ph_r)
        2'd0:    lo_r <= lo_nxt;
        2'd1:    hi_r <= hi_nxt;
        default: res_r[q_r] <= sum_b[HW-1:0];
      endcase
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign res  = res_r;

endmodule

FILE: sim/tb_top.sv
module tb_top;
  import bss_pkg::*;

  // Index past the end of the register list; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam longint Q_ONE = 65536;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;

  typedef struct {
    bit        side;
    bit [1:0]  row;
    bit [1:0]  col;
    bit [31:0] x;
    bit [31:0] y;
    bit [31:0] z;
    bit [30:0] w;
    bit        last;
  } patch_point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bss_in_if  in_if();
  bss_out_if out_if();

  bezier_surface_split_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_if),
    .out_bus  (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // Mirror of the block: configuration and control grid.
  int unsigned deg_u = 3, deg_v = 3;
  bit          rat_on = 1'b0;
  longint      span_beg[2] = '{0, 0};
  longint      span_end[2] = '{65536, 65536};
  longint      grid_x[16], grid_y[16], grid_z[16], grid_w[16];

  patch_point_t patch_points_due[$];
  bit  failed = 1'b0;
  int  tx_idle_pct = 0, rx_idle_pct = 0;
  int  rx_hold_left = 0;

  // b + floor((a - b) * alpha / 1.0)
  function automatic longint lerp_q16(longint a, longint b, longint alpha);
    longint d, m, lo, q;
    d = a - b;
    m = (d < 0) ? -d : d;
    lo = (m & 64'hFFFF) * alpha;
    q = (m >>> 16) * alpha + (lo >>> 16);
    if (d < 0) return b - q - (((lo & 64'hFFFF) != 0) ? 1 : 0);
    return b + q;
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // Run de Casteljau on every line of the grid and queue both sub-patches.
  function automatic void predict_split(logic [31:0] at, bit along_v);
    longint hom[16][4];
    longint part[2][16][4];
    longint st, en, t, alpha, hw;
    int unsigned idx[4];
    int unsigned lines, dg, n, e, total, cnt;
    patch_point_t pt;
    st = along_v ? span_beg[1] : span_beg[0];
    en = along_v ? span_end[1] : span_end[0];
    t = longint'(signed'(at));
    alpha = 0;
    if (en > st) begin
      if (t < st) t = st;
      if (t > en) t = en;
      alpha = ((t - st) << 16) / (en - st);
    end
    for (int i = 0; i < 16; i++) begin
      hw = rat_on ? grid_w[i] : Q_ONE;
      hom[i][0] = rat_on ? (grid_x[i] * hw) >>> 16 : grid_x[i];
      hom[i][1] = rat_on ? (grid_y[i] * hw) >>> 16 : grid_y[i];
      hom[i][2] = rat_on ? (grid_z[i] * hw) >>> 16 : grid_z[i];
      hom[i][3] = hw;
    end
    lines = along_v ? deg_u : deg_v;
    dg = along_v ? deg_v : deg_u;
    for (int ln = 0; ln <= lines; ln++) begin
      for (int p = 0; p <= dg; p++) idx[p] = along_v ? ln * 4 + p : p * 4 + ln;
      for (int q = 0; q < 4; q++) begin
        part[0][idx[0]][q] = hom[idx[0]][q];
        part[1][idx[dg]][q] = hom[idx[dg]][q];
      end
      for (int k = 1; k <= dg; k++) begin
        for (int p = dg; p >= k; p--)
          for (int q = 0; q < 4; q++)
            hom[idx[p]][q] = lerp_q16(hom[idx[p]][q], hom[idx[p-1]][q], alpha);
        for (int q = 0; q < 4; q++) begin
          part[0][idx[k]][q] = hom[idx[k]][q];
          part[1][idx[dg-k]][q] = hom[idx[dg]][q];
        end
        if (rat_on) begin
          for (int s = 0; s < 2; s++) begin
            e = (s == 0) ? idx[k] : idx[dg-k];
            hw = part[s][e][3];
            for (int q = 0; q < 3; q++)
              part[s][e][q] = (hw > 0) ? clamp_coord((part[s][e][q] * Q_ONE) / hw) : 0;
          end
        end
      end
      // End points of each line pass through untouched.
      part[0][idx[0]][0] = grid_x[idx[0]];
      part[0][idx[0]][1] = grid_y[idx[0]];
      part[0][idx[0]][2] = grid_z[idx[0]];
      part[1][idx[dg]][0] = grid_x[idx[dg]];
      part[1][idx[dg]][1] = grid_y[idx[dg]];
      part[1][idx[dg]][2] = grid_z[idx[dg]];
      part[0][idx[0]][3] = rat_on ? grid_w[idx[0]] : Q_ONE;
      part[1][idx[dg]][3] = rat_on ? grid_w[idx[dg]] : Q_ONE;
    end
    total = 2 * (deg_u + 1) * (deg_v + 1);
    cnt = 0;
    for (int s = 0; s < 2; s++)
      for (int i = 0; i <= deg_u; i++)
        for (int j = 0; j <= deg_v; j++) begin
          n = i * 4 + j;
          cnt++;
          pt.side = s[0];
          pt.row = i[1:0];
          pt.col = j[1:0];
          pt.x = part[s][n][0][31:0];
          pt.y = part[s][n][1][31:0];
          pt.z = part[s][n][2][31:0];
          pt.w = rat_on ? part[s][n][3][30:0] : ONE_Q16;
          pt.last = (cnt == total);
          patch_points_due.push_back(pt);
        end
  endfunction

  // Hold one beat on the input channel until accepted, then update the mirror.
  task automatic send_beat(logic kind, logic [1:0] row, logic [1:0] col,
                           logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [30:0] w, logic [31:0] at, logic dir);
    int n;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.kind <= kind;
    in_if.grid_row <= row;
    in_if.grid_col <= col;
    in_if.coord_x <= x;
    in_if.coord_y <= y;
    in_if.coord_z <= z;
    in_if.point_weight <= w;
    in_if.split_at <= at;
    in_if.split_dir <= dir;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (kind == KIND_LOAD) begin
      n = row * 4 + col;
      grid_x[n] = longint'(signed'(x));
      grid_y[n] = longint'(signed'(y));
      grid_z[n] = longint'(signed'(z));
      grid_w[n] = longint'(w);
    end else begin
      predict_split(at, dir);
    end
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'($signed($urandom_range(2097152)) - 1048576);
      default: return 32'($signed($urandom_range(1310720)) - 655360);
    endcase
  endfunction

  function automatic logic [30:0] rand_weight();
    case ($urandom_range(3))
      0: return 31'($urandom_range(32'h7FFF_FFFF, 1));
      1: return 31'($urandom_range(16, 1));
      default: return 31'($urandom_range(262144, 16384));
    endcase
  endfunction

  task automatic send_load(logic [1:0] row, logic [1:0] col, logic [31:0] x,
                           logic [31:0] y, logic [31:0] z, logic [30:0] w);
    send_beat(KIND_LOAD, row, col, x, y, z, w, $urandom, $urandom_range(1));
  endtask

  task automatic send_split(logic [31:0] at, logic dir);
    send_beat(KIND_SPLIT, 2'($urandom), 2'($urandom), $urandom, $urandom, $urandom,
              31'($urandom), at, dir);
  endtask

  // Drain outstanding points and let the block settle before touching registers.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (patch_points_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Write every register back to back; upper junk bits on the narrow ones are masked.
  task automatic set_config(int unsigned du, int unsigned dv, bit rat,
                            logic [31:0] ub, logic [31:0] ue,
                            logic [31:0] vb, logic [31:0] ve);
    logic [CFG_IDX_W-1:0] idx[8];
    logic [31:0] val[8];
    idx = '{CFG_DEGREE_U, CFG_DEGREE_V, CFG_RATIONAL, CFG_SPAN_U_BEG,
            CFG_SPAN_U_END, CFG_SPAN_V_BEG, CFG_SPAN_V_END, CFG_UNUSED};
    val = '{{30'($urandom), du[1:0]}, {30'($urandom), dv[1:0]},
            {31'($urandom), rat}, ub, ue, vb, ve, $urandom};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    deg_u = du;
    deg_v = dv;
    rat_on = rat;
    span_beg = '{longint'(signed'(ub)), longint'(signed'(vb))};
    span_end = '{longint'(signed'(ue)), longint'(signed'(ve))};
  endtask

  task automatic rand_span(output logic [31:0] b, output logic [31:0] e);
    case ($urandom_range(5))
      0: begin b = 32'h8000_0000; e = 32'h7FFF_FFFF; end
      1: begin b = $urandom; e = b; end
      2: begin b = $urandom; e = $urandom; end
      3: begin b = 32'd0; e = 32'd65536; end
      default: begin
        b = 32'($signed($urandom_range(400000)) - 200000);
        e = b + $urandom_range(300000, 1);
      end
    endcase
  endtask

  task automatic rand_config();
    logic [31:0] ub, ue, vb, ve;
    rand_span(ub, ue);
    rand_span(vb, ve);
    set_config($urandom_range(3), $urandom_range(3), $urandom_range(1), ub, ue, vb, ve);
  endtask

  function automatic logic [31:0] rand_split_at(bit dir);
    longint b, e;
    b = span_beg[dir];
    e = span_end[dir];
    case ($urandom_range(5))
      0: return $urandom;
      1: return b[31:0];
      2: return e[31:0];
      default: return (e > b) ? 32'(b + longint'($urandom) % (e - b + 1)) : $urandom;
    endcase
  endfunction

  // Extremes of every field, both directions, clamping, degree zero, empty span.
  task automatic test_directed();
    for (int i = 0; i < 16; i++)
      send_load(2'(i / 4), 2'(i % 4),
                (i == 0) ? 32'h7FFF_FFFF : (i == 5) ? 32'h8000_0000 : 32'(i * 70000),
                (i == 15) ? 32'h8000_0000 : 32'(-i * 50000),
                (i == 10) ? 32'h7FFF_FFFF : 32'(i * 12345),
                (i == 3) ? 31'h7FFF_FFFF : (i == 12) ? 31'd1 : 31'(65536 + i * 4096));
    send_split(32'd0, 1'b0);
    send_split(32'd65536, 1'b1);
    send_split(32'h8000_0000, 1'b0);
    send_split(32'h7FFF_FFFF, 1'b1);
    send_split(32'd21845, 1'b0);
    wait_idle();
    set_config(0, 3, 1'b1, 32'd0, 32'd65536, 32'd65536, 32'd0);
    send_split(32'd30000, 1'b0);
    send_split(32'd30000, 1'b1);
    wait_idle();
    set_config(3, 3, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'd100, 32'd100);
    send_split(32'd12345, 1'b0);
    send_split(32'd100, 1'b1);
    wait_idle();
  endtask

  // Mostly reloads with fresh content mixed with splits, under a random setting.
  task automatic test_random_phase(int items, int tx_pct, int rx_pct);
    bit dir;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int ph = 0; ph < items / 25; ph++) begin
      rand_config();
      for (int i = 0; i < 25; i++) begin
        if ($urandom_range(99) < 55) begin
          send_load(2'($urandom), 2'($urandom), rand_coord(), rand_coord(), rand_coord(),
                    rand_weight());
        end else begin
          dir = $urandom_range(1);
          send_split(rand_split_at(dir), dir);
        end
      end
      wait_idle();
    end
  endtask

  // Stall the receiver for a long stretch so the block backs up into its input.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_config(3, 3, 1'b1, 32'd0, 32'd65536, 32'd0, 32'd65536);
    rx_hold_left = 3000;
    for (int i = 0; i < 6; i++) send_split(rand_split_at(i[0]), i[0]);
    for (int i = 0; i < 4; i++)
      send_load(2'($urandom), 2'($urandom), rand_coord(), rand_coord(), rand_coord(),
                rand_weight());
    send_split(32'd40000, 1'b1);
    wait_idle();
  endtask

  // Receiver: random stalls, or a long hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare every accepted output beat against the oldest predicted point.
  always @(posedge clk) begin
    patch_point_t exp_pt;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (patch_points_due.size() == 0) begin
        $error("unexpected output beat");
        failed = 1'b1;
      end else begin
        exp_pt = patch_points_due.pop_front();
        if (out_if.side !== exp_pt.side) begin
          $error("side exp %0d got %0d", exp_pt.side, out_if.side); failed = 1'b1;
        end
        if (out_if.out_row !== exp_pt.row) begin
          $error("out_row exp %0d got %0d", exp_pt.row, out_if.out_row); failed = 1'b1;
        end
        if (out_if.out_col !== exp_pt.col) begin
          $error("out_col exp %0d got %0d", exp_pt.col, out_if.out_col); failed = 1'b1;
        end
        if (out_if.out_x !== exp_pt.x) begin
          $error("out_x exp %h got %h", exp_pt.x, out_if.out_x); failed = 1'b1;
        end
        if (out_if.out_y !== exp_pt.y) begin
          $error("out_y exp %h got %h", exp_pt.y, out_if.out_y); failed = 1'b1;
        end
        if (out_if.out_z !== exp_pt.z) begin
          $error("out_z exp %h got %h", exp_pt.z, out_if.out_z); failed = 1'b1;
        end
        if (out_if.out_weight !== exp_pt.w) begin
          $error("out_weight exp %h got %h", exp_pt.w, out_if.out_weight); failed = 1'b1;
        end
        if (out_if.last !== exp_pt.last) begin
          $error("last exp %0d got %0d", exp_pt.last, out_if.last); failed = 1'b1;
        end
      end
    end
  end

  initial begin
    in_if.valid <= 1'b0;
    in_if.kind <= KIND_LOAD;
    in_if.grid_row <= '0;
    in_if.grid_col <= '0;
    in_if.coord_x <= '0;
    in_if.coord_y <= '0;
    in_if.coord_z <= '0;
    in_if.point_weight <= '0;
    in_if.split_at <= '0;
    in_if.split_dir <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(150, 35, 47);
    test_random_phase(150, 47, 35);
    test_backpressure();
    test_random_phase(125, 0, 0);
    wait_idle();
    repeat (50) @(posedge clk);
    if (!failed && patch_points_due.size() == 0) begin
      $display("bezier_surface_split_top test passed");
    end else begin
      $display("bezier_surface_split_top test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #60000000;
    $display("bezier_surface_split_top test failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/bss_pkg.sv
rtl/bss_in_if.sv
rtl/bss_out_if.sv
rtl/bss_ram.sv
rtl/bss_div.sv
rtl/bss_lerp.sv
rtl/bezier_surface_split_top.sv
sim/tb_top.sv
